// ===== rtl/udup_pkg.sv =====
// ----------------------------------------------------------------------------
// udup_pkg
// Shared types and codes of the tile de-duplication block.
// ----------------------------------------------------------------------------
package udup_pkg;

   // control bits that travel with each pixel along the cell chain
   typedef struct packed {
      logic valid;
      logic cmp;
      logic last;
      logic found;
   } chain_ctl_type;

   typedef enum logic [1:0] {
      FEED_STREAM,
      FEED_PAD,
      FEED_WAIT
   } feed_state_type;

   // register index codes, taken from paddr[2]
   localparam logic [0:0] CSR_TILE_PIXELS = 1'b0;

   localparam logic [8:0] TILE_PIXELS_RESET = 9'd256;

endpackage

// ===== rtl/unique_tile_dedup.sv =====
// ----------------------------------------------------------------------------
// unique_tile_dedup
// Exact-match tile de-duplication over a chain of tile slot cells.
// ----------------------------------------------------------------------------
// result: valid once the last pixel, and any zero pixels padded onto a short tile,
//   has passed every cell of the chain and reached the result register
// throughput: one pixel per cycle inside a tile, but the last pixel is held off while a
//   result waits for transfer; the next tile starts only after the pass along the chain
// reset: clears control and stored count, sets match flags, tile_pixels to 256;
//   the tile memories are not cleared
module unique_tile_dedup #(
   parameter int MAX_TILES       = 64,
   parameter int MAX_TILE_PIXELS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_pixel_value,
   input  logic        req_last_pixel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_duplicate,
   output logic [5:0]  rsp_tile_index,
   output logic        rsp_table_full,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int PW = (MAX_TILE_PIXELS > 1) ? $clog2(MAX_TILE_PIXELS) : 1;
   localparam int LW = $clog2(MAX_TILE_PIXELS + 1);
   localparam int IW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
   localparam int CW = $clog2(MAX_TILES + 1);

   logic [8:0]    tile_pixels_ff;
   logic [CW-1:0] count_ff;
   logic          rsp_valid_ff;
   logic          rsp_dup_ff;
   logic [5:0]    rsp_index_ff;
   logic          rsp_full_ff;

   udup_pkg::chain_ctl_type chain_ctl [MAX_TILES+1];
   logic [PW-1:0] chain_pos   [MAX_TILES+1];
   logic [31:0]   chain_value [MAX_TILES+1];
   logic [LW-1:0] chain_len   [MAX_TILES+1];
   logic [IW-1:0] chain_hit   [MAX_TILES+1];

   udup_pkg::chain_ctl_type end_ctl;
   logic          capture;
   logic          room;
   logic [31:0]   hit32;
   logic [31:0]   cnt32;
   logic          csr_write;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == udup_pkg::CSR_TILE_PIXELS);
   assign csr_prdata = (csr_paddr[2] == udup_pkg::CSR_TILE_PIXELS) ?
                       {23'd0, tile_pixels_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_pixels_ff <= udup_pkg::TILE_PIXELS_RESET;
      end else if (csr_write) begin
         tile_pixels_ff <= csr_pwdata[8:0];
      end
   end

   udup_feed #(
      .MAX_TILE_PIXELS (MAX_TILE_PIXELS)
   ) u_feed (
      .clock           (clock),
      .reset           (reset),
      .tile_pixels     (tile_pixels_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_value (req_pixel_value),
      .req_last_pixel  (req_last_pixel),
      .rsp_busy        (rsp_valid_ff),
      .done            (capture),
      .tok_ctl         (chain_ctl[0]),
      .tok_pos         (chain_pos[0]),
      .tok_value       (chain_value[0]),
      .tok_len         (chain_len[0])
   );

   assign chain_hit[0] = '0;

   for (genvar t = 0; t < MAX_TILES; t++) begin : g_cell
      udup_cell #(
         .MAX_TILES       (MAX_TILES),
         .MAX_TILE_PIXELS (MAX_TILE_PIXELS),
         .IDX             (t)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .count     (count_ff),
         .in_ctl    (chain_ctl[t]),
         .in_pos    (chain_pos[t]),
         .in_value  (chain_value[t]),
         .in_len    (chain_len[t]),
         .in_hit    (chain_hit[t]),
         .out_ctl   (chain_ctl[t+1]),
         .out_pos   (chain_pos[t+1]),
         .out_value (chain_value[t+1]),
         .out_len   (chain_len[t+1]),
         .out_hit   (chain_hit[t+1])
      );
   end

   // tile decision at the end of the chain
   assign end_ctl = chain_ctl[MAX_TILES];
   assign capture = end_ctl.valid && end_ctl.last;
   assign cnt32   = 32'(count_ff);
   assign hit32   = 32'(chain_hit[MAX_TILES]);
   assign room    = cnt32 < MAX_TILES;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         if (capture) begin
            rsp_valid_ff <= 1'b1;
            if (!end_ctl.found && room) begin
               count_ff <= count_ff + CW'(1);
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         rsp_dup_ff   <= end_ctl.found;
         rsp_index_ff <= end_ctl.found ? hit32[5:0] : (room ? cnt32[5:0] : 6'd0);
         rsp_full_ff  <= !end_ctl.found && !room;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_duplicate = rsp_dup_ff;
   assign rsp_tile_index   = rsp_index_ff;
   assign rsp_table_full   = rsp_full_ff;

   // a tile result never lands on a result still waiting for transfer
   a_capture_free: assert property (@(posedge clock) disable iff (reset)
      capture |-> !rsp_valid_ff)
      else $error("tile result overwrote a pending result");

   // stored count moves only on a new-tile decision
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> ($past(capture) && !$past(end_ctl.found)))
      else $error("stored count changed outside a commit");

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= MAX_TILES)
      else $error("stored count beyond table size");

   // a full table result is never a duplicate
   a_full_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_dup_ff && rsp_full_ff))
      else $error("duplicate and table full both set");

endmodule

// ===== rtl/udup_feed.sv =====
// ----------------------------------------------------------------------------
// udup_feed
// Head of the chain: counts pixel positions, pads short tiles with zero
// pixels and holds off new pixels until the tile result is captured.
// ----------------------------------------------------------------------------
module udup_feed #(
   parameter int MAX_TILE_PIXELS = 256,
   localparam int PW = (MAX_TILE_PIXELS > 1) ? $clog2(MAX_TILE_PIXELS) : 1,
   localparam int LW = $clog2(MAX_TILE_PIXELS + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [8:0]              tile_pixels,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [31:0]             req_pixel_value,
   input  logic                    req_last_pixel,
   input  logic                    rsp_busy,
   input  logic                    done,
   output udup_pkg::chain_ctl_type tok_ctl,
   output logic [PW-1:0]           tok_pos,
   output logic [31:0]             tok_value,
   output logic [LW-1:0]           tok_len
);

   udup_pkg::feed_state_type state_ff, state_in;
   udup_pkg::chain_ctl_type  tok_ctl_ff, tok_ctl_in;
   logic [PW-1:0] tok_pos_ff, tok_pos_in;
   logic [31:0]   tok_value_ff, tok_value_in;
   logic [LW-1:0] tok_len_ff, tok_len_in;
   logic [LW-1:0] pos_ff, pos_in;
   logic [LW-1:0] pad_len_ff, pad_len_in;

   logic [31:0]   cfg32;
   logic [31:0]   len32;
   logic [LW-1:0] len;
   logic [LW:0]   pos_inc;
   logic          in_range;
   logic          short_tile;
   logic          pad_end;
   logic          accept;

   // tile length saturated to 1 .. MAX_TILE_PIXELS
   assign cfg32 = 32'(tile_pixels);
   assign len32 = (cfg32 == 32'd0) ? 32'd1 :
                  (cfg32 > MAX_TILE_PIXELS) ? 32'(MAX_TILE_PIXELS) : cfg32;
   assign len   = len32[LW-1:0];

   assign pos_inc    = {1'b0, pos_ff} + (LW+1)'(1);
   assign in_range   = pos_ff < len;
   assign short_tile = in_range && (pos_inc < {1'b0, len});
   assign pad_end    = pos_inc == {1'b0, pad_len_ff};

   assign req_stall = (state_ff != udup_pkg::FEED_STREAM) || (req_last_pixel && rsp_busy);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         udup_pkg::FEED_STREAM: begin
            if (accept && req_last_pixel) begin
               state_in = short_tile ? udup_pkg::FEED_PAD : udup_pkg::FEED_WAIT;
            end
         end
         udup_pkg::FEED_PAD: begin
            if (pad_end) begin
               state_in = udup_pkg::FEED_WAIT;
            end
         end
         udup_pkg::FEED_WAIT: begin
            if (done) begin
               state_in = udup_pkg::FEED_STREAM;
            end
         end
         default: state_in = udup_pkg::FEED_STREAM;
      endcase
   end

   always_comb begin
      tok_ctl_in   = '0;
      tok_pos_in   = tok_pos_ff;
      tok_value_in = tok_value_ff;
      tok_len_in   = tok_len_ff;
      pos_in       = pos_ff;
      pad_len_in   = pad_len_ff;
      unique case (state_ff)
         udup_pkg::FEED_STREAM: begin
            if (accept) begin
               if (in_range || req_last_pixel) begin
                  tok_ctl_in.valid = 1'b1;
                  tok_ctl_in.cmp   = in_range;
                  tok_ctl_in.last  = req_last_pixel && !short_tile;
                  tok_pos_in       = pos_ff[PW-1:0];
                  tok_value_in     = req_pixel_value;
                  tok_len_in       = len;
               end
               if (in_range) begin
                  pos_in = pos_inc[LW-1:0];
               end
               if (req_last_pixel && short_tile) begin
                  pad_len_in = len;
               end
            end
         end
         udup_pkg::FEED_PAD: begin
            tok_ctl_in.valid = 1'b1;
            tok_ctl_in.cmp   = 1'b1;
            tok_ctl_in.last  = pad_end;
            tok_pos_in       = pos_ff[PW-1:0];
            tok_value_in     = 32'd0;
            tok_len_in       = pad_len_ff;
            pos_in           = pos_inc[LW-1:0];
         end
         udup_pkg::FEED_WAIT: begin
            if (done) begin
               pos_in = '0;
            end
         end
         default: begin
            pos_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= udup_pkg::FEED_STREAM;
         tok_ctl_ff <= '0;
         pos_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         tok_ctl_ff <= tok_ctl_in;
         pos_ff     <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_pos_ff   <= tok_pos_in;
      tok_value_ff <= tok_value_in;
      tok_len_ff   <= tok_len_in;
      pad_len_ff   <= pad_len_in;
   end

   assign tok_ctl   = tok_ctl_ff;
   assign tok_pos   = tok_pos_ff;
   assign tok_value = tok_value_ff;
   assign tok_len   = tok_len_ff;

endmodule

// ===== rtl/udup_cell.sv =====
// ----------------------------------------------------------------------------
// udup_cell
// One stored tile slot: pixel memory, stored length and match flag. Compares
// the passing pixel, writes ahead when it is the free slot and hands the
// pixel on to the next cell.
// ----------------------------------------------------------------------------
module udup_cell #(
   parameter int MAX_TILES       = 64,
   parameter int MAX_TILE_PIXELS = 256,
   parameter int IDX             = 0,
   localparam int PW = (MAX_TILE_PIXELS > 1) ? $clog2(MAX_TILE_PIXELS) : 1,
   localparam int LW = $clog2(MAX_TILE_PIXELS + 1),
   localparam int IW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1,
   localparam int CW = $clog2(MAX_TILES + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [CW-1:0]           count,
   input  udup_pkg::chain_ctl_type in_ctl,
   input  logic [PW-1:0]           in_pos,
   input  logic [31:0]             in_value,
   input  logic [LW-1:0]           in_len,
   input  logic [IW-1:0]           in_hit,
   output udup_pkg::chain_ctl_type out_ctl,
   output logic [PW-1:0]           out_pos,
   output logic [31:0]             out_value,
   output logic [LW-1:0]           out_len,
   output logic [IW-1:0]           out_hit
);

   logic [31:0] mem [MAX_TILE_PIXELS];

   udup_pkg::chain_ctl_type ctl_ff;
   logic [PW-1:0] pos_ff;
   logic [31:0]   value_ff;
   logic [LW-1:0] len_ff;
   logic [IW-1:0] hit_ff;
   logic [31:0]   rdata_ff;
   logic [LW-1:0] slot_len_ff;
   logic          match_ff, match_in;

   logic          is_free;
   logic          active;
   logic [31:0]   stored;
   logic          eq;
   logic          match_now;

   assign is_free = count == CW'(IDX);
   assign active  = CW'(IDX) < count;

   always_ff @(posedge clock) begin
      if (in_ctl.valid && in_ctl.cmp && is_free) begin
         mem[in_pos] <= in_value;
      end
      rdata_ff <= mem[in_pos];
   end

   always_ff @(posedge clock) begin
      pos_ff   <= in_pos;
      value_ff <= in_value;
      len_ff   <= in_len;
      hit_ff   <= in_hit;
      if (in_ctl.valid && in_ctl.last && is_free) begin
         slot_len_ff <= in_len;
      end
   end

   // positions past the stored length read as zero
   assign stored    = (LW'(pos_ff) < slot_len_ff) ? rdata_ff : 32'd0;
   assign eq        = stored == value_ff;
   assign match_now = match_ff && (!ctl_ff.cmp || eq);

   always_comb begin
      match_in = match_ff;
      if (ctl_ff.valid) begin
         if (ctl_ff.last) begin
            match_in = 1'b1;
         end else if (active && ctl_ff.cmp && !eq) begin
            match_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff   <= '0;
         match_ff <= 1'b1;
      end else begin
         ctl_ff   <= in_ctl;
         match_ff <= match_in;
      end
   end

   always_comb begin
      out_ctl       = ctl_ff;
      out_ctl.found = ctl_ff.found || (ctl_ff.last && active && match_now);
      out_hit       = ctl_ff.found ? hit_ff : IW'(IDX);
   end

   assign out_pos   = pos_ff;
   assign out_value = value_ff;
   assign out_len   = len_ff;

endmodule
